// File: src/pcv_pkg.sv
// Package for the PNG chunk validator: failure cause codes, chunk type codes,
// the file signature table and the byte-wide CRC-32 update. No dependencies.
package pcv_pkg;

    typedef enum logic [2:0] {
        CAUSE_NONE     = 3'd0,
        CAUSE_BAD_SIG  = 3'd1,
        CAUSE_BAD_CRC  = 3'd2,
        CAUSE_TRUNC    = 3'd3,
        CAUSE_NO_IHDR  = 3'd4
    } t_cause;

    localparam logic [31:0] KIND_IHDR = 32'h4948_4452;
    localparam logic [31:0] KIND_IEND = 32'h4945_4E44;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    // Result of one byte as handed from the parser to the output stage.
    typedef struct packed {
        logic   emit;
        logic   ok;
        t_cause cause;
    } t_result;

    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            3'd7:    b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Reflected CRC-32, one byte per call: eight shift steps.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: src/pcv_if.sv
// Valid/ready channel interfaces for the PNG chunk validator.
// No dependencies.
interface pcv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_end;

    modport source (output valid, output data_byte, output file_end, input ready);
    modport sink   (input valid, input data_byte, input file_end, output ready);
endinterface

interface pcv_out_if;
    logic       valid;
    logic       ready;
    logic       verdict_ok;
    logic [2:0] fail_cause;

    modport source (output valid, output verdict_ok, output fail_cause, input ready);
    modport sink   (input valid, input verdict_ok, input fail_cause, output ready);
endinterface

// File: src/pcv_parser.sv
// Chunk parser of the PNG chunk validator: per-file state, CRC accumulation and
// the verdict for each byte. Depends on pcv_pkg.
module pcv_parser
    import pcv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_result    o_res
);

    typedef enum logic [2:0] {
        PH_SIG  = 3'd0,
        PH_LEN  = 3'd1,
        PH_TYPE = 3'd2,
        PH_DATA = 3'd3,
        PH_CRC  = 3'd4,
        PH_DONE = 3'd5
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_cnt,    n_cnt;
    logic [31:0] r_len,    n_len;
    logic [31:0] r_crc,    n_crc;
    logic [31:0] r_claim,  n_claim;
    logic [31:0] r_kind,   n_kind;
    logic        r_hdr,    n_hdr;

    t_result     res;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_len     = r_len;
        n_crc     = r_crc;
        n_claim   = r_claim;
        n_kind    = r_kind;
        n_hdr     = r_hdr;
        res.emit  = 1'b0;
        res.ok    = 1'b0;
        res.cause = CAUSE_NONE;

        case (r_phase)
            PH_SIG: begin
                if (i_byte != sig_byte(r_cnt)) begin
                    res.emit  = 1'b1;
                    res.cause = CAUSE_BAD_SIG;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                    if (r_cnt == 3'd7) begin
                        n_phase = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                n_len = {r_len[23:0], i_byte};
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_cnt   = 3'd0;
                    n_crc   = CRC_INIT;
                    n_kind  = '0;
                    n_phase = PH_TYPE;
                end
            end
            PH_TYPE: begin
                n_crc  = crc_byte(r_crc, i_byte);
                n_kind = {r_kind[23:0], i_byte};
                n_cnt  = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_cnt   = 3'd0;
                    n_claim = '0;
                    n_phase = (r_len != '0) ? PH_DATA : PH_CRC;
                end
            end
            PH_DATA: begin
                n_crc = crc_byte(r_crc, i_byte);
                n_len = r_len - 32'd1;
                if (r_len == 32'd1) begin
                    n_phase = PH_CRC;
                end
            end
            PH_CRC: begin
                n_claim = {r_claim[23:0], i_byte};
                n_cnt   = r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    n_cnt = 3'd0;
                    if (~r_crc != n_claim) begin
                        res.emit  = 1'b1;
                        res.cause = CAUSE_BAD_CRC;
                    end else if (r_kind == KIND_IEND) begin
                        res.emit  = 1'b1;
                        res.ok    = r_hdr;
                        res.cause = r_hdr ? CAUSE_NONE : CAUSE_NO_IHDR;
                    end else begin
                        if (r_kind == KIND_IHDR) begin
                            n_hdr = 1'b1;
                        end
                        n_len   = '0;
                        n_phase = PH_LEN;
                    end
                end
            end
            default: begin
            end
        endcase

        if (res.emit && !i_last) begin
            n_phase = PH_DONE;
        end else if (!res.emit && i_last) begin
            // A file that ends before any verdict is truncated.
            if (r_phase != PH_DONE) begin
                res.emit  = 1'b1;
                res.cause = CAUSE_TRUNC;
            end
        end

        // The last byte always rearms the parser for the next file.
        if (i_last) begin
            n_phase = PH_SIG;
            n_cnt   = '0;
            n_len   = '0;
            n_crc   = CRC_INIT;
            n_claim = '0;
            n_kind  = '0;
            n_hdr   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG;
            r_cnt   <= '0;
            r_len   <= '0;
            r_crc   <= CRC_INIT;
            r_claim <= '0;
            r_kind  <= '0;
            r_hdr   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_claim <= n_claim;
            r_kind  <= n_kind;
            r_hdr   <= n_hdr;
        end
    end

    assign o_res = res;

endmodule

// File: src/png_chunk_validator.sv
// PNG chunk validator, top level: input register, parser and result register.
// Depends on pcv_pkg, pcv_if.sv (pcv_in_if, pcv_out_if) and pcv_parser.
//
// The validator takes one file byte per cycle on i_in and gives at most one verdict
// per file on o_out: verdict_ok, and fail_cause (bad signature, CRC mismatch,
// truncated file, or IEND without IHDR). The verdict of the deciding byte is registered
// in the result register. Throughput is one byte per clock while o_out is not stalled;
// the cycle is set by the byte-wide CRC-32 update between the input and state registers.
// After a verdict the remaining bytes of the file, up to the one with file_end, are
// consumed silently, and the byte after file_end starts a new file.
module png_chunk_validator
    import pcv_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    pcv_in_if.sink         i_in,
    pcv_out_if.source      o_out
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_out_valid;
    logic       r_ok;
    t_cause     r_cause;

    logic       advance;
    t_result    res;

    // The held byte moves into the parser once the result register has room.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.data_byte;
            r_last <= i_in.file_end;
        end
    end

    pcv_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
            r_cause     <= CAUSE_NONE;
        end else if (advance && res.emit) begin
            r_out_valid <= 1'b1;
            r_ok        <= res.ok;
            r_cause     <= res.cause;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.verdict_ok = r_ok;
    assign o_out.fail_cause = r_cause;

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && res.emit |=> r_out_valid)
        else $error("decided verdict did not reach the result register");

    a_ok_no_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_ok |-> r_cause == CAUSE_NONE)
        else $error("passing verdict carries a failure cause");

    a_fail_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ok |-> r_cause != CAUSE_NONE)
        else $error("failing verdict has no cause");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_byte) && $stable(r_last))
        else $error("held input byte lost while the result register was full");

endmodule
